FILE: design/rsas_pkg.sv
package rsas_pkg;

   localparam int VALUE_W = 32;

   // Item codes on the request channel
   typedef enum logic [1:0] {
      MODE_LOAD  = 2'd0,
      MODE_QUERY = 2'd1,
      MODE_CLEAR = 2'd2
   } mode_type;

   // Datapath operations issued by the controller
   typedef enum logic [3:0] {
      OP_NONE,
      OP_LOAD,
      OP_CLEAR,
      OP_START,
      OP_KM,
      OP_ROT_CMP,
      OP_ROT_EQ,
      OP_SEL_ALL,
      OP_SEL_SEG,
      OP_SRCH_CMP,
      OP_PUSH
   } op_type;

   // Read address select for the element store
   typedef enum logic [1:0] {
      RD_MID,
      RD_HI,
      RD_HIM1,
      RD_ZERO
   } rd_sel_type;

   typedef struct packed {
      op_type     op;
      rd_sel_type rd_sel;
   } cmd_type;

   typedef struct packed {
      logic cnt_zero;  // store is empty
      logic lo_lt_hi;  // search window not yet closed
      logic km_gt;     // probe at mid above probe at hi
      logic km_lt;     // probe at mid below probe at hi
      logic hm1_gt;    // entry below hi is a descent
      logic lo_zero;   // rotation point is at index zero
      logic hit;       // probed entry equals the target
   } status_type;

endpackage

FILE: design/rsas_if.sv
interface rsas_req_if;
   logic                               valid;
   logic                               ready;
   logic [1:0]                         mode;
   logic signed [rsas_pkg::VALUE_W-1:0] value;

   modport source (output valid, output mode, output value, input ready);
   modport sink   (input valid, input mode, input value, output ready);
endinterface

interface rsas_rsp_if;
   logic valid;
   logic ready;
   logic found;

   modport source (output valid, output found, input ready);
   modport sink   (input valid, input found, output ready);
endinterface

FILE: design/rsas_ctrl.sv
module rsas_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic [1:0]           req_mode,
   output logic                 req_ready,
   input  logic                 rsp_ready,
   output logic                 rsp_valid,
   input  rsas_pkg::status_type status,
   output rsas_pkg::cmd_type    cmd
);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_ROT_CHK,
      ST_ROT_RDH,
      ST_ROT_CMP,
      ST_ROT_EQ,
      ST_SEL,
      ST_SEL_RD,
      ST_SRCH,
      ST_SRCH_CMP,
      ST_FIN
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      rsp_valid_ff;
   logic      out_free;
   logic      push;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign push      = (state_ff == ST_FIN) && out_free;

   // Next state and datapath command
   always_comb begin
      state_in   = state_ff;
      cmd.op     = rsas_pkg::OP_NONE;
      cmd.rd_sel = rsas_pkg::RD_MID;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (req_mode == rsas_pkg::MODE_LOAD) begin
                  cmd.op = rsas_pkg::OP_LOAD;
               end else if (req_mode == rsas_pkg::MODE_CLEAR) begin
                  cmd.op = rsas_pkg::OP_CLEAR;
               end else if (req_mode == rsas_pkg::MODE_QUERY) begin
                  cmd.op   = rsas_pkg::OP_START;
                  state_in = status.cnt_zero ? ST_FIN : ST_ROT_CHK;
               end
            end
         end
         ST_ROT_CHK: begin
            cmd.rd_sel = rsas_pkg::RD_MID;
            state_in   = status.lo_lt_hi ? ST_ROT_RDH : ST_SEL;
         end
         ST_ROT_RDH: begin
            cmd.op     = rsas_pkg::OP_KM;
            cmd.rd_sel = rsas_pkg::RD_HI;
            state_in   = ST_ROT_CMP;
         end
         ST_ROT_CMP: begin
            cmd.op     = rsas_pkg::OP_ROT_CMP;
            cmd.rd_sel = rsas_pkg::RD_HIM1;
            state_in   = (status.km_gt || status.km_lt) ? ST_ROT_CHK : ST_ROT_EQ;
         end
         ST_ROT_EQ: begin
            cmd.op   = rsas_pkg::OP_ROT_EQ;
            state_in = status.hm1_gt ? ST_SEL : ST_ROT_CHK;
         end
         ST_SEL: begin
            cmd.rd_sel = rsas_pkg::RD_ZERO;
            if (status.lo_zero) begin
               cmd.op   = rsas_pkg::OP_SEL_ALL;
               state_in = ST_SRCH;
            end else begin
               state_in = ST_SEL_RD;
            end
         end
         ST_SEL_RD: begin
            cmd.op   = rsas_pkg::OP_SEL_SEG;
            state_in = ST_SRCH;
         end
         ST_SRCH: begin
            cmd.rd_sel = rsas_pkg::RD_MID;
            state_in   = status.lo_lt_hi ? ST_SRCH_CMP : ST_FIN;
         end
         ST_SRCH_CMP: begin
            cmd.op   = rsas_pkg::OP_SRCH_CMP;
            state_in = status.hit ? ST_FIN : ST_SRCH;
         end
         ST_FIN: begin
            if (out_free) begin
               cmd.op   = rsas_pkg::OP_PUSH;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // State and response valid
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (push) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

endmodule

FILE: design/rsas_dp.sv
module rsas_dp #(
   parameter int MAX_ELEMENTS = 1024
) (
   input  logic                                clock,
   input  logic                                reset,
   input  rsas_pkg::cmd_type                   cmd,
   input  logic signed [rsas_pkg::VALUE_W-1:0] req_value,
   output rsas_pkg::status_type                status,
   output logic                                rsp_found
);

   localparam int AW = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;
   localparam int CW = $clog2(MAX_ELEMENTS + 1);
   localparam logic [CW-1:0] MAX_CNT = CW'(MAX_ELEMENTS);

   logic [rsas_pkg::VALUE_W-1:0]        mem [MAX_ELEMENTS];
   logic signed [rsas_pkg::VALUE_W-1:0] rdata_ff;
   logic signed [rsas_pkg::VALUE_W-1:0] km_ff;
   logic signed [rsas_pkg::VALUE_W-1:0] kh_ff;
   logic signed [rsas_pkg::VALUE_W-1:0] target_ff;
   logic [CW-1:0]                       count_ff;
   logic [CW-1:0]                       lo_ff;
   logic [CW-1:0]                       hi_ff;
   logic                                found_ff;
   logic                                rsp_found_ff;
   logic [CW-1:0]                       mid;
   logic [CW-1:0]                       hi_m1;
   logic [AW-1:0]                       raddr;

   assign mid   = lo_ff + ((hi_ff - lo_ff) >> 1);
   assign hi_m1 = hi_ff - CW'(1);

   // Read address mux
   always_comb begin
      case (cmd.rd_sel)
         rsas_pkg::RD_MID:  raddr = mid[AW-1:0];
         rsas_pkg::RD_HI:   raddr = hi_ff[AW-1:0];
         rsas_pkg::RD_HIM1: raddr = hi_m1[AW-1:0];
         default:           raddr = '0;
      endcase
   end

   // Element store: append on load, one registered read per cycle
   always_ff @(posedge clock) begin
      if (cmd.op == rsas_pkg::OP_LOAD && count_ff < MAX_CNT) begin
         mem[count_ff[AW-1:0]] <= req_value;
      end
      rdata_ff <= mem[raddr];
   end

   // Element count
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (cmd.op == rsas_pkg::OP_CLEAR) begin
         count_ff <= '0;
      end else if (cmd.op == rsas_pkg::OP_LOAD && count_ff < MAX_CNT) begin
         count_ff <= count_ff + CW'(1);
      end
   end

   // Search window, probe holding and result
   always_ff @(posedge clock) begin
      case (cmd.op)
         rsas_pkg::OP_START: begin
            lo_ff     <= '0;
            hi_ff     <= count_ff - CW'(1);
            target_ff <= req_value;
            found_ff  <= 1'b0;
         end
         rsas_pkg::OP_KM: km_ff <= rdata_ff;
         rsas_pkg::OP_ROT_CMP: begin
            if (km_ff > rdata_ff) begin
               lo_ff <= mid + CW'(1);
            end else if (km_ff < rdata_ff) begin
               hi_ff <= mid;
            end else begin
               kh_ff <= rdata_ff;
            end
         end
         rsas_pkg::OP_ROT_EQ: begin
            // a descent just below hi marks hi as the rotation point
            if (rdata_ff > kh_ff) begin
               lo_ff <= hi_ff;
            end else begin
               hi_ff <= hi_m1;
            end
         end
         rsas_pkg::OP_SEL_ALL: begin
            lo_ff <= '0;
            hi_ff <= count_ff;
         end
         rsas_pkg::OP_SEL_SEG: begin
            // rdata holds the first element; pick the segment before or after the pivot
            if (target_ff >= rdata_ff) begin
               lo_ff <= '0;
               hi_ff <= lo_ff;
            end else begin
               hi_ff <= count_ff;
            end
         end
         rsas_pkg::OP_SRCH_CMP: begin
            if (rdata_ff == target_ff) begin
               found_ff <= 1'b1;
            end else if (rdata_ff > target_ff) begin
               hi_ff <= mid;
            end else begin
               lo_ff <= mid + CW'(1);
            end
         end
         rsas_pkg::OP_PUSH: rsp_found_ff <= found_ff;
         default: ;
      endcase
   end

   assign status.cnt_zero = (count_ff == '0);
   assign status.lo_lt_hi = (lo_ff < hi_ff);
   assign status.km_gt    = (km_ff > rdata_ff);
   assign status.km_lt    = (km_ff < rdata_ff);
   assign status.hm1_gt   = (rdata_ff > kh_ff);
   assign status.lo_zero  = (lo_ff == '0);
   assign status.hit      = (rdata_ff == target_ff);

   assign rsp_found = rsp_found_ff;

endmodule

FILE: design/rotated_sorted_array_search_top.sv
// Channel   Dir  Payload                       Transaction
// req_chan  in   mode[1:0], value[31:0] signed  valid && ready
// rsp_chan  out  found                         valid && ready
//
// Load and clear give no response.
// Query: a rotation search finds where the sorted order starts, then a binary search probes
// the segment that can hold the value; runs of equal values can make the rotation search
// step the upper end inward one by one, which makes the query longer.
// Synchronous active-high reset empties the store; contents need no clearing pass.
// A waiting result never blocks new transactions; a finished query holds until it is free.
module rotated_sorted_array_search_top #(
   parameter int MAX_ELEMENTS = 1024
) (
   input  logic       clock,
   input  logic       reset,
   rsas_req_if.sink   req_chan,
   rsas_rsp_if.source rsp_chan
);

   rsas_pkg::cmd_type    cmd;
   rsas_pkg::status_type status;

   rsas_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_mode  (req_chan.mode),
      .req_ready (req_chan.ready),
      .rsp_ready (rsp_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .status    (status),
      .cmd       (cmd)
   );

   rsas_dp #(
      .MAX_ELEMENTS (MAX_ELEMENTS)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .req_value (req_chan.value),
      .status    (status),
      .rsp_found (rsp_chan.found)
   );

endmodule

FILE: design/rsas_checker.sv
module rsas_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic [1:0] req_mode,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic       rsp_found
);

   // A response holds until taken
   rsp_hold_a: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped while stalled");

   rsp_stable_a: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_found))
      else $error("response payload changed while stalled");

   // No response appears in the cycle right after any request transaction
   rsp_latency_a: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !$rose(rsp_valid))
      else $error("response rose too soon after a request");

   // A query keeps the block busy in the following cycle
   query_busy_a: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && (req_mode == rsas_pkg::MODE_QUERY) |=> !req_ready)
      else $error("request accepted while a query is in progress");

endmodule

bind rotated_sorted_array_search_top rsas_checker u_rsas_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_chan.valid),
   .req_ready (req_chan.ready),
   .req_mode  (req_chan.mode),
   .rsp_valid (rsp_chan.valid),
   .rsp_ready (rsp_chan.ready),
   .rsp_found (rsp_chan.found)
);

FILE: sim/testbench.sv
`timescale 1ns / 100ps

module testbench;

   localparam int          STORE_DEPTH  = 1024;
   localparam int          ITEM_TARGET  = 650;
   localparam logic [1:0]  MODE_IGNORED = 2'd3;       // unused code, block must ignore it
   localparam logic [31:0] SIGN_FLIP    = 32'h8000_0000;

   typedef struct {
      logic [1:0]  mode;
      logic [31:0] value;
      bit          drain_first;  // hold off until every query has been answered
   } req_txn_type;

   logic clock;
   logic reset;

   rsas_req_if req_chan ();
   rsas_rsp_if rsp_chan ();

   rotated_sorted_array_search_top #(
      .MAX_ELEMENTS(STORE_DEPTH)
   ) dut (
      .clock   (clock),
      .reset   (reset),
      .req_chan(req_chan),
      .rsp_chan(rsp_chan)
   );

   // Clock, 4 ns period
   always begin
      clock = 1'b1;
      #2;
      clock = 1'b0;
      #2;
   end

   // Shadow copy of the element store
   logic [31:0] elem_mem [STORE_DEPTH];
   int unsigned elem_cnt;

   req_txn_type pending_txns [$];
   bit          expected_found [$];
   int          set_vals [$];
   int          items_made;
   int          accepted_count;
   int          error_count;
   logic        req_fired;
   req_txn_type cur_txn;
   int          burst_left;
   int          gap_left;
   int          stall_left;
   int          calm_left;

   function automatic logic [31:0] key_at(int unsigned idx);
      return elem_mem[idx] ^ SIGN_FLIP;
   endfunction

   // Start of the sorted order; steps the upper end inward on equal probes
   function automatic int unsigned rotation_start(int unsigned n);
      int unsigned lo;
      int unsigned hi;
      int unsigned mid;
      logic [31:0] km;
      logic [31:0] kh;
      lo = 0;
      hi = n - 1;
      while (lo < hi) begin
         mid = lo + (hi - lo) / 2;
         km  = key_at(mid);
         kh  = key_at(hi);
         if (km > kh) begin
            lo = mid + 1;
         end else if (km < kh) begin
            hi = mid;
         end else if (key_at(hi - 1) > kh) begin
            lo = hi;
            break;
         end else begin
            hi = hi - 1;
         end
      end
      return lo;
   endfunction

   // Binary search over [lo, hi)
   function automatic bit segment_holds(int unsigned lo, int unsigned hi, logic [31:0] target);
      int unsigned mid;
      logic [31:0] k;
      while (lo < hi) begin
         mid = lo + (hi - lo) / 2;
         k   = key_at(mid);
         if (k == target)
            return 1'b1;
         if (k > target)
            hi = mid;
         else
            lo = mid + 1;
      end
      return 1'b0;
   endfunction

   function automatic bit lookup_target(logic [31:0] value);
      int unsigned n;
      int unsigned pivot;
      logic [31:0] target;
      n      = elem_cnt;
      target = value ^ SIGN_FLIP;
      if (n == 0)
         return 1'b0;
      pivot = rotation_start(n);
      if (pivot == 0)
         return segment_holds(0, n, target);
      if (target >= key_at(0))
         return segment_holds(0, pivot, target);
      return segment_holds(pivot, n, target);
   endfunction

   task automatic report_error(string what, bit exp_val, logic act_val);
      error_count++;
      if (error_count <= 10)
         $display("%0t: %s: expected found=%0d, got found=%0b", $realtime, what, exp_val, act_val);
   endtask

   // Monitor: check responses first, then fold accepted requests into the shadow store
   always @(posedge clock) begin
      if (reset) begin
         req_fired <= 1'b0;
      end else begin
         req_fired <= req_chan.valid && req_chan.ready;
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (expected_found.size() == 0)
               report_error("response with no query pending", 1'b0, rsp_chan.found);
            else if (rsp_chan.found !== expected_found[0])
               report_error("found mismatch", expected_found.pop_front(), rsp_chan.found);
            else
               void'(expected_found.pop_front());
         end
         if (req_chan.valid && req_chan.ready) begin
            accepted_count++;
            case (req_chan.mode)
               rsas_pkg::MODE_LOAD: begin
                  if (elem_cnt < STORE_DEPTH) begin
                     elem_mem[elem_cnt] = req_chan.value;
                     elem_cnt++;
                  end
               end
               rsas_pkg::MODE_CLEAR: begin
                  elem_cnt = 0;
               end
               rsas_pkg::MODE_QUERY: begin
                  expected_found.push_back(lookup_target(req_chan.value));
               end
               default: ;
            endcase
         end
      end
   end

   // Request driver: bursts of random length with random gaps
   always @(negedge clock) begin
      if (reset) begin
         req_chan.valid <= 1'b0;
      end else if (!req_chan.valid || req_fired) begin
         if (gap_left > 0) begin
            gap_left--;
            req_chan.valid <= 1'b0;
         end else if (pending_txns.size() > 0 &&
                      !(pending_txns[0].drain_first && expected_found.size() != 0)) begin
            cur_txn = pending_txns.pop_front();
            req_chan.valid <= 1'b1;
            req_chan.mode  <= cur_txn.mode;
            req_chan.value <= cur_txn.value;
            if (burst_left == 0) begin
               burst_left = $urandom_range(1, 40);
               gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
            end else begin
               burst_left--;
            end
         end else begin
            req_chan.valid <= 1'b0;
         end
      end
   end

   // Response ready: random stalls with calm stretches in between
   always @(negedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_chan.ready <= 1'b0;
      end else begin
         rsp_chan.ready <= 1'b1;
         if (calm_left > 0) begin
            calm_left--;
         end else begin
            case ($urandom_range(0, 9))
               0, 1:    stall_left = $urandom_range(1, 15);
               2:       calm_left  = $urandom_range(20, 200);
               default: ;
            endcase
         end
      end
   end

   task automatic push_txn(logic [1:0] mode, logic [31:0] value, bit drain_first = 1'b0);
      req_txn_type t;
      t.mode        = mode;
      t.value       = value;
      t.drain_first = drain_first;
      pending_txns.push_back(t);
      if (mode != MODE_IGNORED)
         items_made++;
   endtask

   // Sorted values, possibly with duplicates, rotated by a random amount
   task automatic build_rotated(int n, bit wide);
      int base;
      int span;
      int shift;
      set_vals.delete();
      base = $urandom;
      span = $urandom_range(0, 3 * n);
      for (int i = 0; i < n; i++)
         set_vals.push_back(wide ? int'($urandom) : base + int'($urandom_range(0, span)));
      set_vals.sort();
      shift = $urandom_range(0, n - 1);
      repeat (shift) set_vals.push_back(set_vals.pop_front());
   endtask

   task automatic build_unsorted(int n);
      set_vals.delete();
      for (int i = 0; i < n; i++)
         set_vals.push_back($urandom);
   endtask

   task automatic query_values(int count);
      int pick;
      for (int i = 0; i < count; i++) begin
         pick = (set_vals.size() == 0) ? int'($urandom)
                                       : set_vals[$urandom_range(0, set_vals.size() - 1)];
         case ($urandom_range(0, 5))
            0, 1, 2: push_txn(rsas_pkg::MODE_QUERY, pick);
            3:       push_txn(rsas_pkg::MODE_QUERY, pick + 1);
            4:       push_txn(rsas_pkg::MODE_QUERY, pick - 1);
            default: push_txn(rsas_pkg::MODE_QUERY, $urandom);
         endcase
      end
   endtask

   // Loads, with the odd ignored code or early query mixed in
   task automatic load_values();
      foreach (set_vals[i]) begin
         if ($urandom_range(0, 19) == 0)
            push_txn(MODE_IGNORED, $urandom);
         if ($urandom_range(0, 29) == 0)
            query_values(1);
         push_txn(rsas_pkg::MODE_LOAD, set_vals[i]);
      end
   endtask

   // Stimulus and end of run
   initial begin
      int set_no;
      int kind;
      int total_txns;

      reset          = 1'b1;
      req_chan.valid = 1'b0;
      req_chan.mode  = rsas_pkg::MODE_LOAD;
      req_chan.value = '0;
      rsp_chan.ready = 1'b0;
      req_fired      = 1'b0;
      elem_cnt       = 0;
      items_made     = 0;
      accepted_count = 0;
      error_count    = 0;
      burst_left     = 0;
      gap_left       = 0;
      stall_left     = 0;
      calm_left      = 0;

      // Directed: empty store, signed extremes across the wrap, ignored code
      push_txn(rsas_pkg::MODE_QUERY, 32'h0000_0000);
      set_vals = '{0, 7, 7, 32'h7FFF_FFFF, 32'h8000_0000, -1};
      load_values();
      push_txn(rsas_pkg::MODE_QUERY, 32'h8000_0000);
      push_txn(rsas_pkg::MODE_QUERY, 32'h7FFF_FFFF);
      push_txn(MODE_IGNORED, 32'h8000_0000);
      push_txn(rsas_pkg::MODE_QUERY, 7);
      push_txn(rsas_pkg::MODE_QUERY, -1);
      push_txn(rsas_pkg::MODE_QUERY, 3);
      push_txn(rsas_pkg::MODE_QUERY, 0);
      push_txn(rsas_pkg::MODE_CLEAR, 32'hFFFF_FFFF);
      push_txn(rsas_pkg::MODE_QUERY, 7);
      // Pivot hidden among duplicates
      set_vals = '{2, 2, 2, 0, 2};
      load_values();
      push_txn(rsas_pkg::MODE_QUERY, 0);
      push_txn(rsas_pkg::MODE_QUERY, 2);
      push_txn(rsas_pkg::MODE_QUERY, 1);

      // Random sets, each starting from a cleared store
      set_no = 0;
      while (items_made < ITEM_TARGET) begin
         set_no++;
         push_txn(rsas_pkg::MODE_CLEAR, $urandom, (set_no % 8) == 0);
         kind = $urandom_range(0, 19);
         if (set_no == 5)
            build_rotated(300, 1'b0);               // one deep set for long searches
         else if (kind < 14)
            build_rotated(($urandom_range(0, 9) == 0) ? $urandom_range(25, 200)
                                                      : $urandom_range(1, 24),
                          $urandom_range(0, 2) == 0);
         else if (kind < 17)
            build_unsorted($urandom_range(1, 20));
         else
            set_vals.delete();
         load_values();
         if (kind == 13 && set_vals.size() > 0)
            push_txn(rsas_pkg::MODE_LOAD, $urandom);  // breaks the rotated order
         query_values($urandom_range(2, 8));
      end
      total_txns = pending_txns.size();

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      while (accepted_count < total_txns || expected_found.size() != 0)
         @(posedge clock);
      repeat (100) @(posedge clock);

      if (error_count == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

   // Watchdog
   initial begin
      #20_000_000;
      $display("FAILURE");
      $finish;
   end

endmodule

FILE: rotated_sorted_array_search_top.f
design/rsas_pkg.sv
design/rsas_if.sv
design/rsas_ctrl.sv
design/rsas_dp.sv
design/rotated_sorted_array_search_top.sv
design/rsas_checker.sv
sim/testbench.sv
